/* hdl/tfsk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tfsk_pkg;

   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned LENGTH_W  = 5;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned FRAME_W   = 12;
   localparam int unsigned BITCNT_W  = $clog2(FRAME_W + 1);
   localparam int unsigned ADDR_W    = 4;
   localparam int unsigned DATA_W    = 32;

   localparam logic [LENGTH_W-1:0] SHORT_FAST = LENGTH_W'(8);
   localparam logic [LENGTH_W-1:0] LONG_FAST  = LENGTH_W'(16);
   localparam logic [LENGTH_W-1:0] SHORT_SLOW = LENGTH_W'(9);
   localparam logic [LENGTH_W-1:0] LONG_SLOW  = LENGTH_W'(18);

   localparam logic [LEVEL_W-1:0] HIGH_RESET = 8'he0;
   localparam logic [LEVEL_W-1:0] LOW_RESET  = 8'h20;

   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_BIT   = 1'b1;

   typedef enum logic [1:0] {
      REG_FAST_MODE  = 2'd0,
      REG_HIGH_LEVEL = 2'd1,
      REG_LOW_LEVEL  = 2'd2
   } tfsk_reg_type;

   typedef struct packed {
      logic load;
      logic step;
   } tfsk_cmd_type;

   typedef struct packed {
      logic out_free;
      logic item_last;
   } tfsk_status_type;

   typedef struct packed {
      logic               fast_mode;
      logic [LEVEL_W-1:0] high_level;
      logic [LEVEL_W-1:0] low_level;
   } tfsk_cfg_type;

endpackage

`default_nettype wire

/* hdl/tfsk_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfsk_regs (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [tfsk_pkg::ADDR_W-1:0] paddr,
   input  wire logic [tfsk_pkg::DATA_W-1:0] pwdata,
   output logic      [tfsk_pkg::DATA_W-1:0] prdata,
   output logic                            pready,
   output tfsk_pkg::tfsk_cfg_type          cfg
);
   import tfsk_pkg::*;

   logic               fast_mode_ff;
   logic               fast_mode_in;
   logic [LEVEL_W-1:0] high_level_ff;
   logic [LEVEL_W-1:0] high_level_in;
   logic [LEVEL_W-1:0] low_level_ff;
   logic [LEVEL_W-1:0] low_level_in;
   logic               wr_en;
   tfsk_reg_type       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = tfsk_reg_type'(paddr[3:2]);

   always_comb begin
      fast_mode_in  = fast_mode_ff;
      high_level_in = high_level_ff;
      low_level_in  = low_level_ff;
      prdata        = '0;
      unique case (reg_sel)
         REG_FAST_MODE: begin
            prdata = DATA_W'(fast_mode_ff);
            if (wr_en) begin
               fast_mode_in = pwdata[0];
            end
         end
         REG_HIGH_LEVEL: begin
            prdata = DATA_W'(high_level_ff);
            if (wr_en) begin
               high_level_in = pwdata[LEVEL_W-1:0];
            end
         end
         REG_LOW_LEVEL: begin
            prdata = DATA_W'(low_level_ff);
            if (wr_en) begin
               low_level_in = pwdata[LEVEL_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff  <= 1'b0;
         high_level_ff <= HIGH_RESET;
         low_level_ff  <= LOW_RESET;
      end else begin
         fast_mode_ff  <= fast_mode_in;
         high_level_ff <= high_level_in;
         low_level_ff  <= low_level_in;
      end
   end

   assign cfg.fast_mode  = fast_mode_ff;
   assign cfg.high_level = high_level_ff;
   assign cfg.low_level  = low_level_ff;

endmodule

`default_nettype wire

/* hdl/tfsk_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfsk_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire tfsk_pkg::tfsk_status_type status,
   output tfsk_pkg::tfsk_cmd_type         cmd
);
   import tfsk_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff == ST_RUN);

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.item_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/tfsk_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfsk_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tfsk_pkg::tfsk_cmd_type        cmd,
   output tfsk_pkg::tfsk_status_type          status,
   input  wire tfsk_pkg::tfsk_cfg_type        cfg,
   input  wire logic                          req_cmd,
   input  wire logic [tfsk_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [tfsk_pkg::LEVEL_W-1:0]  rsp_sample_level,
   output logic      [tfsk_pkg::LENGTH_W-1:0] rsp_run_length,
   output logic                               rsp_last_of_run
);
   import tfsk_pkg::*;

   logic [FRAME_W-1:0]  frame_ff;
   logic [FRAME_W-1:0]  frame_in;
   logic [BITCNT_W-1:0] bits_left_ff;
   logic [BITCNT_W-1:0] bits_left_in;
   logic [1:0]          run_idx_ff;
   logic [1:0]          run_idx_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [LEVEL_W-1:0]  level_ff;
   logic [LEVEL_W-1:0]  level_in;
   logic [LENGTH_W-1:0] length_ff;
   logic [LENGTH_W-1:0] length_in;
   logic                last_ff;
   logic                last_in;

   logic                cur_bit;
   logic                bit_done;
   logic [LENGTH_W-1:0] short_len;
   logic [LENGTH_W-1:0] long_len;

   assign cur_bit   = frame_ff[0];
   assign bit_done  = cur_bit ? (run_idx_ff == 2'd3) : (run_idx_ff == 2'd1);
   assign short_len = cfg.fast_mode ? SHORT_FAST : SHORT_SLOW;
   assign long_len  = cfg.fast_mode ? LONG_FAST : LONG_SLOW;

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.item_last = bit_done && (bits_left_ff == BITCNT_W'(1));

   always_comb begin
      frame_in     = frame_ff;
      bits_left_in = bits_left_ff;
      run_idx_in   = run_idx_ff;
      level_in     = level_ff;
      length_in    = length_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         run_idx_in = 2'd0;
         if (req_cmd == CMD_BIT) begin
            frame_in     = FRAME_W'(req_data_byte[0]);
            bits_left_in = BITCNT_W'(1);
         end else begin
            frame_in     = {3'b111, req_data_byte, 1'b0};
            bits_left_in = BITCNT_W'(FRAME_W);
         end
      end else if (cmd.step) begin
         rsp_valid_in = 1'b1;
         level_in     = run_idx_ff[0] ? cfg.low_level : cfg.high_level;
         length_in    = cur_bit ? short_len : long_len;
         last_in      = status.item_last;
         if (bit_done) begin
            run_idx_in   = 2'd0;
            frame_in     = {1'b0, frame_ff[FRAME_W-1:1]};
            bits_left_in = bits_left_ff - BITCNT_W'(1);
         end else begin
            run_idx_in = run_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bits_left_ff <= '0;
         run_idx_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         bits_left_ff <= bits_left_in;
         run_idx_ff   <= run_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff  <= frame_in;
      level_ff  <= level_in;
      length_ff <= length_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_level = level_ff;
   assign rsp_run_length   = length_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

`default_nettype wire

/* hdl/tape_fsk_byte_modulator.sv */
// Channel   Direction  Handshake              Contents
// req       in         req_valid / req_stall  req_cmd, req_data_byte
// rsp       out        rsp_valid / rsp_stall  rsp_sample_level, rsp_run_length, rsp_last_of_run
// csr       in         APB (psel, penable)    fast_mode, high_level, low_level
//
// A request is loaded first and then sent as half-cycle runs while rsp is not
// stalled: 2 or 4 runs for a single bit, 30 to 46 for a framed byte.
// The run sequencer issues one run per cycle while rsp is not stalled.
// Reset is synchronous and returns the registers to their default levels.
// A stalled rsp holds its run and freezes the sequencer; req_stall is high until the
// last run of a request has entered the output register.
`timescale 1ns / 1ps
`default_nettype none

module tape_fsk_byte_modulator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_cmd,
   input  wire logic [tfsk_pkg::BYTE_W-1:0]   req_data_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [tfsk_pkg::LEVEL_W-1:0]  rsp_sample_level,
   output logic      [tfsk_pkg::LENGTH_W-1:0] rsp_run_length,
   output logic                               rsp_last_of_run,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [tfsk_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [tfsk_pkg::DATA_W-1:0]   pwdata,
   output logic      [tfsk_pkg::DATA_W-1:0]   prdata,
   output logic                               pready
);
   import tfsk_pkg::*;

   tfsk_cfg_type    cfg;
   tfsk_cmd_type    cmd;
   tfsk_status_type status;

   tfsk_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tfsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tfsk_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_level (rsp_sample_level),
      .rsp_run_length   (rsp_run_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

`default_nettype wire

/* hdl/tfsk_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tfsk_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [tfsk_pkg::LENGTH_W-1:0] rsp_run_length,
   input wire logic                          rsp_last_of_run
);
   import tfsk_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted but block not busy");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_length == SHORT_FAST || rsp_run_length == LONG_FAST ||
                     rsp_run_length == SHORT_SLOW || rsp_run_length == LONG_SLOW))
      else $error("illegal run length");

   a_done_marks_last: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(req_stall)) |-> (rsp_valid && rsp_last_of_run))
      else $error("request finished without a marked last run");

endmodule

bind tape_fsk_byte_modulator tfsk_checker u_checker (.*);

`default_nettype wire

/* test/tb_tape_fsk_byte_modulator.sv */
`timescale 1ns / 1ps

module tb_tape_fsk_byte_modulator;
   import tfsk_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int HOLD_CYCLES    = 300;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_REQUESTS = 27;

   localparam logic [LENGTH_W-1:0] FAST_SHORT_RUN = 5'd8;
   localparam logic [LENGTH_W-1:0] FAST_LONG_RUN  = 5'd16;
   localparam logic [LENGTH_W-1:0] SLOW_SHORT_RUN = 5'd9;
   localparam logic [LENGTH_W-1:0] SLOW_LONG_RUN  = 5'd18;

   typedef struct packed {
      logic [LEVEL_W-1:0]  sample_level;
      logic [LENGTH_W-1:0] run_length;
      logic                last_of_run;
   } fsk_run_type;

   class fsk_run_scoreboard;
      fsk_run_type        pending_runs[$];
      logic               fast_mode;
      logic [LEVEL_W-1:0] high_level;
      logic [LEVEL_W-1:0] low_level;
      int                 failures;
      int                 frames_sent;
      int                 bits_sent;
      int                 runs_checked;
      int                 settings;

      function new();
         fast_mode  = 1'b0;
         high_level = 8'he0;
         low_level  = 8'h20;
         failures = 0;
         frames_sent = 0;
         bits_sent = 0;
         runs_checked = 0;
         settings = 1;
      endfunction

      function void set_register(tfsk_reg_type index, logic [DATA_W-1:0] value);
         case (index)
            REG_FAST_MODE: begin
               fast_mode = value[0];
            end
            REG_HIGH_LEVEL: begin
               high_level = value[LEVEL_W-1:0];
            end
            REG_LOW_LEVEL: begin
               low_level = value[LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void push_tone_bit(logic bit_value);
         logic [LENGTH_W-1:0] period;
         fsk_run_type         run;
         int                  count;
         if (bit_value) begin
            period = fast_mode ? FAST_SHORT_RUN : SLOW_SHORT_RUN;
            count  = 4;
         end else begin
            period = fast_mode ? FAST_LONG_RUN : SLOW_LONG_RUN;
            count  = 2;
         end
         for (int i = 0; i < count; i++) begin
            run.sample_level = (i % 2 == 0) ? high_level : low_level;
            run.run_length   = period;
            run.last_of_run  = 1'b0;
            pending_runs.push_back(run);
         end
      endfunction

      function void predict_request(logic cmd, logic [BYTE_W-1:0] data_byte);
         fsk_run_type final_run;
         if (cmd == CMD_BIT) begin
            push_tone_bit(data_byte[0]);
            bits_sent++;
         end else begin
            push_tone_bit(1'b0);
            for (int i = 0; i < BYTE_W; i++) begin
               push_tone_bit(data_byte[i]);
            end
            for (int i = 0; i < 3; i++) begin
               push_tone_bit(1'b1);
            end
            frames_sent++;
         end
         final_run = pending_runs.pop_back();
         final_run.last_of_run = 1'b1;
         pending_runs.push_back(final_run);
      endfunction

      function void check_run(logic [LEVEL_W-1:0] sample_level,
                              logic [LENGTH_W-1:0] run_length, logic last_of_run);
         fsk_run_type want;
         if (pending_runs.size() == 0) begin
            $error("Unexpected run: sample_level %0d run_length %0d last_of_run %0d",
                   sample_level, run_length, last_of_run);
            failures++;
         end else begin
            want = pending_runs.pop_front();
            runs_checked++;
            if (sample_level !== want.sample_level) begin
               $error("sample_level: expected %0d, actual %0d", want.sample_level,
                      sample_level);
               failures++;
            end
            if (run_length !== want.run_length) begin
               $error("run_length: expected %0d, actual %0d", want.run_length, run_length);
               failures++;
            end
            if (last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                      last_of_run);
               failures++;
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_cmd = CMD_FRAME;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [LEVEL_W-1:0]  rsp_sample_level;
   logic [LENGTH_W-1:0] rsp_run_length;
   logic                rsp_last_of_run;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   fsk_run_scoreboard board = new();
   int  cycle_count = 0;
   int  sender_idle_pct = 12;
   int  receiver_idle_pct = 12;
   bit  hold_request = 1'b0;
   int  hold_left = 0;

   tape_fsk_byte_modulator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_level (rsp_sample_level),
      .rsp_run_length   (rsp_run_length),
      .rsp_last_of_run  (rsp_last_of_run),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles.", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // The receiver counts its own long hold-off once the stimulus asks for one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_run(rsp_sample_level, rsp_run_length, rsp_last_of_run);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [BYTE_W-1:0] data_byte);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_cmd       <= cmd;
      req_data_byte <= data_byte;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.predict_request(cmd, data_byte);
   endtask

   task automatic drain_runs();
      req_valid <= 1'b0;
      while (board.pending_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input tfsk_reg_type index, input logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(4 * int'(index));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_register(index, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (readback !== value) begin
         $error("register %s readback: expected %0d, actual %0d", index.name(), value,
                readback);
         board.failures++;
      end
   endtask

   task automatic apply_settings(input logic fast, input logic [LEVEL_W-1:0] high_value,
                                 input logic [LEVEL_W-1:0] low_value);
      write_register(REG_FAST_MODE, DATA_W'(fast));
      write_register(REG_HIGH_LEVEL, DATA_W'(high_value));
      write_register(REG_LOW_LEVEL, DATA_W'(low_value));
      board.settings++;
   endtask

   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0: pick_level = 8'h00;
         1: pick_level = 8'hff;
         default: pick_level = LEVEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic                cmd;
      logic [BYTE_W-1:0]   data_byte;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(CMD_FRAME, 8'h00);
      send_request(CMD_FRAME, 8'hff);
      send_request(CMD_FRAME, 8'ha5);
      send_request(CMD_FRAME, 8'h5a);
      send_request(CMD_BIT, 8'h00);
      send_request(CMD_BIT, 8'h01);
      send_request(CMD_BIT, 8'hfe);
      send_request(CMD_BIT, 8'hff);
      drain_runs();

      apply_settings(1'b1, 8'hff, 8'h00);
      send_request(CMD_FRAME, 8'h80);
      send_request(CMD_FRAME, 8'h01);
      send_request(CMD_BIT, 8'hfe);
      send_request(CMD_BIT, 8'h7f);
      send_request(CMD_FRAME, 8'hc3);
      drain_runs();

      apply_settings(1'b0, 8'h00, 8'hff);
      send_request(CMD_FRAME, 8'h3c);
      send_request(CMD_BIT, 8'h01);
      send_request(CMD_BIT, 8'h80);
      send_request(CMD_FRAME, 8'hff);
      drain_runs();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(phase % 2 == 0, pick_level(), pick_level());
         sender_idle_pct   = (phase == 0) ? 0 : 12;
         receiver_idle_pct = (phase == 0) ? 0 : 12;
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            cmd       = ($urandom_range(0, 99) < 65) ? CMD_FRAME : CMD_BIT;
            data_byte = BYTE_W'($urandom_range(0, 255));
            send_request(cmd, data_byte);
            if (phase == 3 && n == PHASE_REQUESTS / 2) begin
               drain_runs();
            end
         end
         drain_runs();
      end

      $display("Sent %0d framed bytes and %0d single bits; %0d runs checked.",
               board.frames_sent, board.bits_sent, board.runs_checked);
      $display("Covered %0d register settings, a long output hold-off and full drains.",
               board.settings);
      if (board.failures == 0 && board.pending_runs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/tfsk_pkg.sv
hdl/tfsk_regs.sv
hdl/tfsk_ctrl.sv
hdl/tfsk_datapath.sv
hdl/tape_fsk_byte_modulator.sv
hdl/tfsk_checker.sv
test/tb_tape_fsk_byte_modulator.sv
